FILE: src/bounded_double_ended_queue_defines.svh
// ---------------------------------------------------------------------------
// bounded deque assertion macros
// shared property wrappers for the deque checks
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication
`define BDEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// delayed implication
`define BDEQ_ASSERT_LAT2(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

FILE: src/bdeq_pkg.sv
// ---------------------------------------------------------------------------
// bdeq_pkg
// types and constants shared by the bounded deque modules
// ---------------------------------------------------------------------------
package bdeq_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int CAP_W          = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_IS_EMPTY   = 3'd6,
    OP_IS_FULL    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
  } ctrl_cmd_t;

endpackage

FILE: src/bounded_double_ended_queue.sv
// ---------------------------------------------------------------------------
// bounded_double_ended_queue
// ring-buffer deque with a programmable capacity
// ---------------------------------------------------------------------------
// A request (operation, push_value) is taken on a clock edge with start high
// and busy low. Operations: push front/back, pop front/back, peek front/back,
// empty query, full query. busy stays high while the request runs.
// result_valid pulses for one cycle in the respond state, which follows the
// execute state (which acts on the entry ram and starts its registered
// read); the next request can be taken once the deque is idle again, so
// requests do not overlap. The single ram port limits each request to one
// entry access.
// result_valid carries ok_flag, read_value (nonzero only for a successful
// peek) and the empty/full status after the request. The receiver cannot
// stall: it must take the result in the cycle it is shown.
// capacity is written via cfg_wr_en/cfg_wr_data only while idle: a user rule,
// not enforced. Values above DEPTH act as DEPTH, zero makes every push fail.
// Reset empties the deque, sets the capacity to 1024 and drops any request
// in flight; ram contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
`include "bounded_double_ended_queue_defines.svh"

module bounded_double_ended_queue #(
  parameter int DEPTH      = bdeq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdeq_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 operation,
  input  logic [DATA_WIDTH-1:0]      push_value,
  input  logic                       cfg_wr_en,
  input  logic [bdeq_pkg::CAP_W-1:0] cfg_wr_data,
  output logic                       result_valid,
  output logic                       ok_flag,
  output logic [DATA_WIDTH-1:0]      read_value,
  output logic                       is_empty_now,
  output logic                       is_full_now
);

  bdeq_pkg::ctrl_cmd_t cmd;

  bdeq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  bdeq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .operation    (operation),
    .push_value   (push_value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .ok_flag      (ok_flag),
    .read_value   (read_value),
    .is_empty_now (is_empty_now),
    .is_full_now  (is_full_now)
  );

  assign result_valid = cmd.resp;

  `BDEQ_ASSERT_LAT2(a_req_to_resp, clk, rst, start && !busy, result_valid, "late response")
  `BDEQ_ASSERT_NEXT(a_busy_after_req, clk, rst, start && !busy, busy && !result_valid, "no busy")
  `BDEQ_ASSERT_NOW(a_resp_busy, clk, rst, result_valid, busy, "response while idle")
  `BDEQ_ASSERT_NOW(a_fail_zero, clk, rst, result_valid && !ok_flag, read_value == '0, "fail data")

endmodule

FILE: src/bdeq_ram.sv
// ---------------------------------------------------------------------------
// bdeq_ram
// single-port ram, read-first, registered read data
// ---------------------------------------------------------------------------
module bdeq_ram #(
  parameter int WIDTH = bdeq_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = bdeq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/bdeq_ctrl.sv
// ---------------------------------------------------------------------------
// bdeq_ctrl
// request sequencer: capture, execute, respond
// ---------------------------------------------------------------------------
module bdeq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output bdeq_pkg::ctrl_cmd_t cmd
);

  bdeq_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdeq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bdeq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = bdeq_pkg::ST_EXEC;
        end
      end
      bdeq_pkg::ST_EXEC: state_next = bdeq_pkg::ST_RESP;
      bdeq_pkg::ST_RESP: state_next = bdeq_pkg::ST_IDLE;
      default:           state_next = bdeq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      bdeq_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      bdeq_pkg::ST_EXEC: cmd.exec = 1'b1;
      bdeq_pkg::ST_RESP: cmd.resp = 1'b1;
      default:           busy     = 1'b1;
    endcase
  end

endmodule

FILE: src/bdeq_dp.sv
// ---------------------------------------------------------------------------
// bdeq_dp
// ring pointers, entry count, capacity register and entry ram
// ---------------------------------------------------------------------------
module bdeq_dp #(
  parameter int DEPTH      = bdeq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdeq_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bdeq_pkg::ctrl_cmd_t        cmd,
  input  logic [2:0]                 operation,
  input  logic [DATA_WIDTH-1:0]      push_value,
  input  logic                       cfg_wr_en,
  input  logic [bdeq_pkg::CAP_W-1:0] cfg_wr_data,
  output logic                       ok_flag,
  output logic [DATA_WIDTH-1:0]      read_value,
  output logic                       is_empty_now,
  output logic                       is_full_now
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = (CW > bdeq_pkg::CAP_W) ? CW : bdeq_pkg::CAP_W;

  logic [bdeq_pkg::CAP_W-1:0] capacity;
  bdeq_pkg::op_t              op;
  logic [DATA_WIDTH-1:0]      value;
  logic [AW-1:0]              front, front_next;
  logic [CW-1:0]              count, count_next;
  logic                       ok, ok_next;
  logic                       peek_hit, peek_hit_next;

  logic                  empty, full, full_after;
  logic [AW-1:0]         front_dec, front_inc, back_slot, tail_slot;
  logic [SW-1:0]         tail_sum, back_sum;
  logic [CW-1:0]         count_m1;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bdeq_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= bdeq_pkg::op_t'(operation);
      value <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok       <= ok_next;
      peek_hit <= peek_hit_next;
    end
  end

  // capacity saturates at the ring depth
  always_comb begin
    empty      = (count == '0);
    full       = (EW'(count) >= EW'(capacity)) || (count == CW'(DEPTH));
    full_after = (EW'(count) >= EW'(capacity)) || (count == CW'(DEPTH));
  end

  // ring slot arithmetic, the sums stay below twice the depth while not empty
  always_comb begin
    front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
    front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
    count_m1  = count - CW'(1);
    tail_sum  = SW'(front) + SW'(count);
    back_sum  = SW'(front) + SW'(count_m1);
    tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  end

  always_comb begin
    front_next    = front;
    count_next    = count;
    ok_next       = 1'b0;
    peek_hit_next = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = front;
    unique case (op)
      bdeq_pkg::OP_PUSH_FRONT: begin
        ram_addr = front_dec;
        if (!full) begin
          ok_next    = 1'b1;
          ram_we     = cmd.exec;
          front_next = front_dec;
          count_next = count + CW'(1);
        end
      end
      bdeq_pkg::OP_PUSH_BACK: begin
        ram_addr = tail_slot;
        if (!full) begin
          ok_next    = 1'b1;
          ram_we     = cmd.exec;
          count_next = count + CW'(1);
        end
      end
      bdeq_pkg::OP_POP_FRONT: begin
        if (!empty) begin
          ok_next    = 1'b1;
          front_next = front_inc;
          count_next = count_m1;
        end
      end
      bdeq_pkg::OP_POP_BACK: begin
        if (!empty) begin
          ok_next    = 1'b1;
          count_next = count_m1;
        end
      end
      bdeq_pkg::OP_PEEK_FRONT: begin
        ram_addr      = front;
        ok_next       = !empty;
        peek_hit_next = !empty;
      end
      bdeq_pkg::OP_PEEK_BACK: begin
        ram_addr      = back_slot;
        ok_next       = !empty;
        peek_hit_next = !empty;
      end
      bdeq_pkg::OP_IS_EMPTY: ok_next = empty;
      bdeq_pkg::OP_IS_FULL:  ok_next = full;
      default:               ok_next = 1'b0;
    endcase
  end

  bdeq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (value),
    .rdata (ram_rdata)
  );

  // count is already updated when the response is shown
  always_comb begin
    ok_flag      = ok;
    read_value   = peek_hit ? ram_rdata : '0;
    is_empty_now = empty;
    is_full_now  = full_after;
  end

endmodule
